### rtl/rds_pkg.sv
package rds_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned MAX_DIGITS_DEF  = 32;

  localparam int unsigned RADIX_W = 6;
  localparam int unsigned DIGIT_W = 6;
  localparam int unsigned CHAR_W  = 7;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

  // dividend bits retired per divider cycle
  localparam int unsigned DIV_STEP_BITS = 8;

  localparam logic [DIGIT_W-1:0] DIGIT_DEC_LIMIT = 6'd10;
  localparam logic [CHAR_W-1:0]  CHAR_DEC_BASE   = 7'd48;  // '0'
  localparam logic [CHAR_W-1:0]  CHAR_ALPHA_BASE = 7'd55;  // 'A' - 10

  typedef struct packed {
    logic               valid;
    logic [RADIX_W-1:0] radix;
  } q_head_t;

  function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    res = r;
    if (r < RADIX_MIN) res = RADIX_MIN;
    if (r > RADIX_MAX) res = RADIX_MAX;
    return res;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_glyph(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] res;
    if (d < DIGIT_DEC_LIMIT) res = CHAR_W'(d) + CHAR_DEC_BASE;
    else                     res = CHAR_W'(d) + CHAR_ALPHA_BASE;
    return res;
  endfunction

endpackage

### rtl/rds_if.sv
interface rds_value_if #(
  parameter int unsigned VALUE_WIDTH = rds_pkg::VALUE_WIDTH_DEF
) ();
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface rds_char_if ();
  logic                      valid;
  logic                      ready;
  logic [rds_pkg::CHAR_W-1:0] digit_char;
  logic                      last_digit;

  modport source (output valid, output digit_char, output last_digit, input ready);
  modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

### rtl/radix_digit_serializer_unit.sv
// Converts each unsigned value into ASCII digits ('0'-'9', 'A'-'Z') in the base held in the
// radix register (0 and 1 act as base 2, 37 and up as base 36), most significant digit
// first, with last_digit set on the final character; zero gives the single character '0'.
// Values enter a two-entry queue, so two can wait while one is converted. The converter
// is a restoring divider that retires 8 dividend bits per cycle; each division by the base
// yields one digit, least significant first, into the digit store, and the digits are then
// read back from the store most significant first, one read at a time while the output is
// free. A value leaves the queue once the last digit read of the previous one is issued.
// At most MAX_DIGITS least significant digits are kept. Write the radix only while idle.
module radix_digit_serializer_unit #(
  parameter int unsigned VALUE_WIDTH = rds_pkg::VALUE_WIDTH_DEF,
  parameter int unsigned MAX_DIGITS  = rds_pkg::MAX_DIGITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  rds_value_if.sink                   value_i,
  rds_char_if.source                  char_o,
  input  logic                        radix_we_i,
  input  logic [rds_pkg::RADIX_W-1:0] radix_i
);
  import rds_pkg::*;

  logic [RADIX_W-1:0]     radix_q;
  q_head_t                head;
  logic [VALUE_WIDTH-1:0] head_value;
  logic                   pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RADIX_RESET;
    end else if (radix_we_i) begin
      radix_q <= radix_i;
    end
  end

  rds_front #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .value_i      (value_i),
    .radix_i      (radix_q),
    .pop_i        (pop),
    .head_o       (head),
    .head_value_o (head_value)
  );

  rds_back #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .MAX_DIGITS  (MAX_DIGITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_value_i (head_value),
    .pop_o        (pop),
    .char_o       (char_o)
  );

endmodule

### rtl/rds_ram.sv
module rds_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/rds_front.sv
module rds_front #(
  parameter int unsigned VALUE_WIDTH = rds_pkg::VALUE_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  rds_value_if.sink                    value_i,
  input  logic [rds_pkg::RADIX_W-1:0]  radix_i,
  input  logic                         pop_i,
  output rds_pkg::q_head_t             head_o,
  output logic [VALUE_WIDTH-1:0]       head_value_o
);
  import rds_pkg::*;

  localparam int unsigned QDEPTH = 2;

  logic [VALUE_WIDTH-1:0] val_q [QDEPTH];
  logic [RADIX_W-1:0]     rad_q [QDEPTH];
  logic                   wr_ptr_q, wr_ptr_d;
  logic                   rd_ptr_q, rd_ptr_d;
  logic [1:0]             count_q, count_d;
  logic                   push, pop;

  assign value_i.ready = (count_q != 2'(QDEPTH));
  assign push          = value_i.valid && value_i.ready;
  assign pop           = pop_i && (count_q != 2'd0);

  assign head_o.valid  = (count_q != 2'd0);
  assign head_o.radix  = rad_q[rd_ptr_q];
  assign head_value_o  = val_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop  ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop)      count_d = count_q + 2'd1;
    else if (pop && !push) count_d = count_q - 2'd1;
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      val_q[wr_ptr_q] <= value_i.value;
      rad_q[wr_ptr_q] <= eff_radix(radix_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

### rtl/rds_back.sv
module rds_back #(
  parameter int unsigned VALUE_WIDTH = rds_pkg::VALUE_WIDTH_DEF,
  parameter int unsigned MAX_DIGITS  = rds_pkg::MAX_DIGITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  rds_pkg::q_head_t       head_i,
  input  logic [VALUE_WIDTH-1:0] head_value_i,
  output logic                   pop_o,
  rds_char_if.source             char_o
);
  import rds_pkg::*;

  localparam int unsigned DIV_W     = ((VALUE_WIDTH + DIV_STEP_BITS - 1) / DIV_STEP_BITS)
                                      * DIV_STEP_BITS;
  localparam int unsigned DIV_STEPS = DIV_W / DIV_STEP_BITS;
  localparam int unsigned SW        = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
  localparam int unsigned CNT_W     = $clog2(MAX_DIGITS + 1);
  localparam int unsigned AW        = $clog2(MAX_DIGITS);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_EMIT = 3'b100
  } bk_state_e;

  bk_state_e          state_q, state_d;
  logic [DIV_W-1:0]   work_q, work_d, work_nx;
  logic [DIGIT_W-1:0] rem_q, rem_d, rem_nx;
  logic [RADIX_W-1:0] radix_q, radix_d;
  logic [SW-1:0]      step_q, step_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [CNT_W-1:0]   rd_left_q, rd_left_d;
  logic               rd_pend_q, rd_pend_d;
  logic               rd_last_q, rd_last_d;
  logic               out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]  out_char_q, out_char_d;
  logic               out_last_q, out_last_d;

  logic               last_step, digit_we, rd_issue, div_done;
  logic [DIGIT_W:0]   trial;
  logic [DIGIT_W-1:0] rdata;

  // restoring division, DIV_STEP_BITS quotient bits per cycle
  always_comb begin
    work_nx = work_q;
    rem_nx  = rem_q;
    trial   = '0;
    for (int j = 0; j < DIV_STEP_BITS; j++) begin
      trial   = {rem_nx, work_nx[DIV_W-1]};
      work_nx = {work_nx[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, radix_q}) begin
        trial      = trial - {1'b0, radix_q};
        work_nx[0] = 1'b1;
      end
      rem_nx = trial[DIGIT_W-1:0];
    end
  end

  assign last_step = (step_q == SW'(DIV_STEPS - 1));
  assign digit_we  = (state_q == S_DIV) && last_step;
  assign div_done  = (work_nx == '0) || (cnt_q == CNT_W'(MAX_DIGITS - 1));
  assign rd_issue  = (state_q == S_EMIT) && !rd_pend_q && (!out_valid_q || char_o.ready);
  assign pop_o     = (state_q == S_IDLE) && head_i.valid;

  rds_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (MAX_DIGITS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (digit_we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (rem_nx),
    .re_i    (rd_issue),
    .raddr_i (AW'(rd_left_q - CNT_W'(1))),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d     = state_q;
    work_d      = work_q;
    rem_d       = rem_q;
    radix_d     = radix_q;
    step_d      = step_q;
    cnt_d       = cnt_q;
    rd_left_d   = rd_left_q;
    rd_pend_d   = 1'b0;
    rd_last_d   = rd_last_q;
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;

    case (state_q)
      S_IDLE: begin
        if (head_i.valid) begin
          work_d  = DIV_W'(head_value_i);
          rem_d   = '0;
          radix_d = head_i.radix;
          step_d  = '0;
          cnt_d   = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (last_step) begin
          if (div_done) begin
            rd_left_d = cnt_q + CNT_W'(1);
            state_d   = S_EMIT;
          end else begin
            work_d = work_nx;
            rem_d  = '0;
            step_d = '0;
            cnt_d  = cnt_q + CNT_W'(1);
          end
        end else begin
          work_d = work_nx;
          rem_d  = rem_nx;
          step_d = step_q + SW'(1);
        end
      end
      S_EMIT: begin
        if (rd_issue) begin
          rd_left_d = rd_left_q - CNT_W'(1);
          rd_last_d = (rd_left_q == CNT_W'(1));
          rd_pend_d = 1'b1;
          if (rd_left_q == CNT_W'(1)) state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (rd_pend_q) begin
      out_valid_d = 1'b1;
      out_char_d  = digit_glyph(rdata);
      out_last_d  = rd_last_q;
    end else if (out_valid_q && char_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  assign char_o.valid      = out_valid_q;
  assign char_o.digit_char = out_char_q;
  assign char_o.last_digit = out_last_q;

  always_ff @(posedge clk_i) begin
    work_q     <= work_d;
    rem_q      <= rem_d;
    radix_q    <= radix_d;
    rd_last_q  <= rd_last_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      cnt_q       <= '0;
      rd_left_q   <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      cnt_q       <= cnt_d;
      rd_left_q   <= rd_left_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### sim/radix_digit_serializer_unit_tb.sv
module radix_digit_serializer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rds_pkg::*;

  localparam int unsigned VW           = VALUE_WIDTH_DEF;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 250;
  localparam int unsigned PHASE_ITEMS  = 42;
  localparam int unsigned PHASE_COUNT  = 12;

  typedef struct packed {
    logic [CHAR_W-1:0] glyph;
    logic              is_last;
  } char_result_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid    = 1'b0;
  logic [VW-1:0]      in_value    = '0;
  logic               out_ready   = 1'b0;
  logic               radix_we    = 1'b0;
  logic [RADIX_W-1:0] radix_wdata = '0;

  logic [RADIX_W-1:0] cfg_radix = RADIX_RESET;
  logic [VW-1:0]      pending_values[$];
  char_result_t       expected_chars[$];
  int unsigned        burst_left;
  int unsigned        gap_left;
  int unsigned        ready_run;
  int unsigned        idle_cycles;
  int                 error_count = 0;

  logic [RADIX_W-1:0] random_radices[10] = '{6'd2, 6'd36, 6'd0, 6'd63, 6'd10,
                                             6'd16, 6'd1, 6'd37, 6'd8, 6'd3};

  rds_value_if #(.VALUE_WIDTH(VW)) value_bus ();
  rds_char_if                      char_bus ();

  assign value_bus.valid = in_valid;
  assign value_bus.value = in_value;
  assign char_bus.ready  = out_ready;

  radix_digit_serializer_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .value_i    (value_bus.sink),
    .char_o     (char_bus.source),
    .radix_we_i (radix_we),
    .radix_i    (radix_wdata)
  );

  always #5 clk_i = ~clk_i;

  function automatic int unsigned base_of(input logic [RADIX_W-1:0] r);
    if (r < RADIX_MIN) return RADIX_MIN;
    if (r > RADIX_MAX) return RADIX_MAX;
    return r;
  endfunction

  // digits of val in the current base, most significant first
  function automatic void expand_value(input logic [VW-1:0] val);
    int unsigned   base;
    logic [VW-1:0] rest;
    int unsigned   digits[$];
    int unsigned   d;
    char_result_t  item;
    base = base_of(cfg_radix);
    rest = val;
    do begin
      digits.push_back(rest % base);
      rest = rest / base;
    end while (rest != 0 && digits.size() < MAX_DIGITS_DEF);
    while (digits.size() != 0) begin
      d = digits.pop_back();
      item.glyph   = (d < 10) ? CHAR_W'(d + "0") : CHAR_W'(d - 10 + "A");
      item.is_last = (digits.size() == 0);
      expected_chars.push_back(item);
    end
  endfunction

  function automatic logic [VW-1:0] random_value();
    logic [63:0] p;
    int unsigned base;
    base = base_of(cfg_radix);
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom;
      3, 4, 5: return $urandom >> $urandom_range(0, VW - 1);
      6:       return $urandom_range(0, 2 * base);
      7, 8: begin
        // powers of the base and their neighbors
        p = 64'd1;
        repeat ($urandom_range(0, 32)) begin
          if (p * base < 64'h1_0000_0000) p = p * base;
        end
        return VW'(p + 64'($urandom_range(0, 2)) - 64'd1);
      end
      default: return ($urandom_range(0, 1) != 0) ? {VW{1'b1}} : {VW{1'b0}};
    endcase
  endfunction

  // sender: bursts of transfers separated by random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid   <= 1'b0;
      in_value   <= '0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (in_valid && value_bus.ready) expand_value(in_value);
      if (!in_valid || value_bus.ready) begin
        if (gap_left != 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_values.size() != 0) begin
          in_valid <= 1'b1;
          in_value <= pending_values.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each transfer, stalls in random runs
  always @(posedge clk_i or negedge rst_ni) begin
    char_result_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
      ready_run <= 0;
    end else begin
      if (char_bus.valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected char: expected none, actual 0x%h last %b",
                   $time, char_bus.digit_char, char_bus.last_digit);
          error_count++;
        end else begin
          want = expected_chars.pop_front();
          if (char_bus.digit_char !== want.glyph) begin
            $display("%0t: digit_char mismatch: expected 0x%h, actual 0x%h",
                     $time, want.glyph, char_bus.digit_char);
            error_count++;
          end
          if (char_bus.last_digit !== want.is_last) begin
            $display("%0t: last_digit mismatch: expected %b, actual %b",
                     $time, want.is_last, char_bus.last_digit);
            error_count++;
          end
        end
      end
      if (ready_run == 0) begin
        if ($urandom_range(0, 3) == 0) begin
          out_ready <= 1'b0;
          ready_run <= $urandom_range(0, 5);
        end else begin
          out_ready <= 1'b1;
          ready_run <= $urandom_range(0, 30);
        end
      end else begin
        ready_run <= ready_run - 1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && value_bus.ready) || (char_bus.valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_values.size() != 0 || in_valid || expected_chars.size() != 0);
  endtask

  task automatic set_radix(input logic [RADIX_W-1:0] r);
    wait_idle();
    @(posedge clk_i);
    radix_we    <= 1'b1;
    radix_wdata <= r;
    @(posedge clk_i);
    radix_we    <= 1'b0;
    @(negedge clk_i);
    cfg_radix = r;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // base 10 out of reset
    pending_values.push_back(32'd0);
    pending_values.push_back(32'd1);
    pending_values.push_back(32'd9);
    pending_values.push_back(32'd10);
    pending_values.push_back(32'd99);
    pending_values.push_back(32'hFFFF_FFFF);
    pending_values.push_back(32'h8000_0000);
    pending_values.push_back(32'd1_000_000_000);

    // 0 and 1 act as base 2; all ones gives the full 32 digits
    set_radix(6'd0);
    pending_values.push_back(32'd0);
    pending_values.push_back(32'hFFFF_FFFF);
    pending_values.push_back(32'h5555_5555);
    set_radix(6'd1);
    pending_values.push_back(32'd1);
    pending_values.push_back(32'hAAAA_AAAA);

    set_radix(6'd36);
    pending_values.push_back(32'd35);
    pending_values.push_back(32'd36);
    pending_values.push_back(32'd1295);
    pending_values.push_back(32'hFFFF_FFFF);

    // above 36 clamps to base 36
    set_radix(6'd63);
    pending_values.push_back(32'd36);
    pending_values.push_back(32'hFFFF_FFFF);
    set_radix(6'd37);
    pending_values.push_back(32'd1);
    pending_values.push_back(32'd71);

    set_radix(6'd16);
    pending_values.push_back(32'hDEAD_BEEF);
    pending_values.push_back(32'h0123_4567);

    for (int i = 0; i < PHASE_COUNT; i++) begin
      set_radix((i < 10) ? random_radices[i] : RADIX_W'($urandom_range(0, 63)));
      repeat (PHASE_ITEMS) pending_values.push_back(random_value());
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
